>>> hdl/scus_pkg.sv
// Shared types and constants for the start code unit splitter.
// No dependencies; imported by scus_plan, start_code_unit_splitter and the testbench files.
package scus_pkg;

  // Marker is three zero bytes followed by this byte
  localparam logic [7:0] MARKER_BYTE  = 8'h01;
  localparam logic [1:0] MARKER_ZEROS = 2'd3;

  // Kind of the middle result of a word's plan
  localparam logic [1:0] MAIN_NONE = 2'd0;
  localparam logic [1:0] MAIN_BYTE = 2'd1;
  localparam logic [1:0] MAIN_END  = 2'd2;

  // Results owed for one input word: zero bytes, then main, then tile close
  typedef struct packed {
    logic [2:0] zeros;      // held zeros to emit first, 0..4
    logic [1:0] main;       // MAIN_* code
    logic [7:0] data;       // byte carried by a MAIN_BYTE result
    logic       pre;        // prefix flag of zeros and main
    logic       kept;       // unit_kept of a MAIN_END result
    logic       tail;       // tile-closing unit end follows
    logic       tail_pre;   // prefix flag of the tile-closing unit end
  } plan_t;

  // Splitter state carried between words
  typedef struct packed {
    logic [1:0] held_zeros;
    logic       marker_seen;
  } split_state_t;

endpackage

>>> hdl/start_code_unit_splitter.sv
// Top level of the start code unit splitter: plan register, emitter, output register.
// Depends on scus_pkg and scus_plan.
//
//   channel | handshake           | payload
//   --------+---------------------+------------------------------------------------
//   in_     | in_valid / in_ready | in_data_byte, in_tile_last
//   out_    | out_valid/out_ready | out_out_byte, out_byte_valid, out_in_prefix,
//           |                     | out_unit_end, out_unit_kept, out_tile_end,
//           |                     | out_run_last
//
// A word causing several results holds the input until the emitter has handed them
// all out, one result per cycle while the output is not stalled.
// An accepted word passes through the plan register, then the output register.
// Synchronous active-low reset clears the state, the plan and the output valid.
// A stalled output holds its register; the plan holds and in_ready drops until
// the plan's last result is loaded.
module start_code_unit_splitter import scus_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_data_byte,
  input  logic       in_tile_last,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_out_byte,
  output logic       out_byte_valid,
  output logic       out_in_prefix,
  output logic       out_unit_end,
  output logic       out_unit_kept,
  output logic       out_tile_end,
  output logic       out_run_last
);

  split_state_t state_r, state_nxt;
  plan_t        plan_r, plan_new;
  logic [2:0]   remaining;
  logic         emit;
  logic         in_acc;

  logic       out_valid_r;
  logic [7:0] out_byte_r;
  logic       byte_valid_r, prefix_r, unit_end_r, unit_kept_r, tile_end_r, run_last_r;

  scus_plan u_plan (
    .data_byte (in_data_byte),
    .tile_last (in_tile_last),
    .cur       (state_r),
    .plan      (plan_new),
    .nxt       (state_nxt)
  );

  // Count results still owed by the current plan
  assign remaining = plan_r.zeros + {2'b00, plan_r.main != MAIN_NONE}
                     + {2'b00, plan_r.tail};
  assign emit      = (remaining != 3'd0) && (!out_valid_r || out_ready);
  assign in_ready  = (remaining == 3'd0) || (remaining == 3'd1 && emit);
  assign in_acc    = in_valid && in_ready;

  // Advance state and plan
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= '0;
      plan_r.zeros  <= 3'd0;
      plan_r.main   <= MAIN_NONE;
      plan_r.tail   <= 1'b0;
    end else if (in_acc) begin
      state_r <= state_nxt;
      plan_r  <= plan_new;
    end else if (emit) begin
      if (plan_r.zeros != 3'd0) begin
        plan_r.zeros <= plan_r.zeros - 3'd1;
      end else if (plan_r.main != MAIN_NONE) begin
        plan_r.main <= MAIN_NONE;
      end else begin
        plan_r.tail <= 1'b0;
      end
    end
  end

  // Load the next result into the output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_byte_r   <= 8'h00;
      byte_valid_r <= 1'b0;
      prefix_r     <= plan_r.pre;
      unit_end_r   <= 1'b0;
      unit_kept_r  <= 1'b0;
      tile_end_r   <= 1'b0;
      run_last_r   <= (remaining == 3'd1);
      if (plan_r.zeros != 3'd0) begin
        byte_valid_r <= 1'b1;
      end else if (plan_r.main == MAIN_BYTE) begin
        out_byte_r   <= plan_r.data;
        byte_valid_r <= 1'b1;
      end else if (plan_r.main == MAIN_END) begin
        unit_end_r  <= 1'b1;
        unit_kept_r <= plan_r.kept;
      end else begin
        prefix_r    <= plan_r.tail_pre;
        unit_end_r  <= 1'b1;
        unit_kept_r <= 1'b1;
        tile_end_r  <= 1'b1;
      end
    end
  end

  assign out_valid      = out_valid_r;
  assign out_out_byte   = out_byte_r;
  assign out_byte_valid = byte_valid_r;
  assign out_in_prefix  = prefix_r;
  assign out_unit_end   = unit_end_r;
  assign out_unit_kept  = unit_kept_r;
  assign out_tile_end   = tile_end_r;
  assign out_run_last   = run_last_r;

  // A plan never owes more than five results
  a_plan_bound: assert property (@(posedge clk) disable iff (!rst_n)
    remaining <= 3'd5)
    else $error("plan owes too many results");

  // The tile's last byte leaves clean state for the next tile
  a_tile_reset: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_tile_last) |=> (state_r.held_zeros == 2'd0 && !state_r.marker_seen))
    else $error("state not cleared at end of tile");

  // A result never carries a byte and a unit end together
  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(byte_valid_r && unit_end_r))
    else $error("byte and unit end on one result");

  // Input is only taken when the old plan is done after this cycle
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |-> (remaining == 3'd0 || (remaining == 3'd1 && emit)))
    else $error("input accepted over a pending plan");

  // A tile end is always the last result of its word
  a_tile_end_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && tile_end_r) |-> run_last_r)
    else $error("tile end not last result");

endmodule

>>> hdl/scus_plan.sv
// Decodes one input word against the splitter state into a result plan.
// Depends on scus_pkg; purely combinational.
module scus_plan import scus_pkg::*; (
  input  logic [7:0]   data_byte,
  input  logic         tile_last,
  input  split_state_t cur,
  output plan_t        plan,
  output split_state_t nxt
);

  logic [2:0] hz_ext;

  assign hz_ext = {1'b0, cur.held_zeros};

  // Classify the byte, then fold in the end of tile
  always_comb begin
    plan          = '0;
    plan.main     = MAIN_NONE;
    plan.data     = data_byte;
    plan.pre      = ~cur.marker_seen;
    nxt           = cur;
    if (data_byte == 8'h00) begin
      if (cur.held_zeros != MARKER_ZEROS) begin
        // hold one more zero; release all on the tile's last byte
        nxt.held_zeros = cur.held_zeros + 2'd1;
        plan.zeros     = tile_last ? (hz_ext + 3'd1) : 3'd0;
      end else begin
        // fourth zero in a row: oldest held zero goes out
        plan.zeros = tile_last ? 3'd4 : 3'd1;
      end
    end else if (data_byte == MARKER_BYTE && cur.held_zeros == MARKER_ZEROS) begin
      // marker found: close the current unit, drop the marker
      plan.main       = MAIN_END;
      plan.kept       = cur.marker_seen;
      nxt.marker_seen = 1'b1;
      nxt.held_zeros  = 2'd0;
    end else begin
      // ordinary byte: held zeros go out first
      plan.zeros     = hz_ext;
      plan.main      = MAIN_BYTE;
      nxt.held_zeros = 2'd0;
    end
    if (tile_last) begin
      plan.tail       = 1'b1;
      plan.tail_pre   = ~nxt.marker_seen;
      nxt.held_zeros  = 2'd0;
      nxt.marker_seen = 1'b0;
    end
  end

endmodule

>>> tb/sv/start_code_unit_splitter_chk.sv
// Checker for the start code unit splitter: watches both channels, predicts results.
// Depends on scus_pkg; instantiated beside the DUT by start_code_unit_splitter_tb.
`timescale 1ns / 100ps

module start_code_unit_splitter_chk import scus_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_ready,
  input  logic [7:0] in_data_byte,
  input  logic       in_tile_last,
  input  logic       out_valid,
  input  logic       out_ready,
  input  logic [7:0] out_out_byte,
  input  logic       out_byte_valid,
  input  logic       out_in_prefix,
  input  logic       out_unit_end,
  input  logic       out_unit_kept,
  input  logic       out_tile_end,
  input  logic       out_run_last,
  output int         owed_count,
  output int         fail_count
);

  typedef struct packed {
    logic [7:0] data;
    logic       byte_valid;
    logic       prefix;
    logic       unit_end;
    logic       kept;
    logic       tile_end;
    logic       run_last;
  } split_result_t;

  // Predicted splitter state
  logic [1:0] held_zeros;
  logic       marker_seen;

  split_result_t owed_results[$];

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    fail_count++;
  endtask

  task automatic check_field(input string name, input logic [7:0] got, input logic [7:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s got %0h want %0h", name, got, want));
  endtask

  task automatic check_bit(input string name, input logic got, input logic want);
    if (got !== want)
      report_mismatch($sformatf("%s got %0b want %0b", name, got, want));
  endtask

  task automatic owe(input logic [7:0] data, input logic bv, input logic pre,
                     input logic uend, input logic kept, input logic tend);
    split_result_t r;
    r.data       = data;
    r.byte_valid = bv;
    r.prefix     = pre;
    r.unit_end   = uend;
    r.kept       = kept;
    r.tile_end   = tend;
    r.run_last   = 1'b0;
    owed_results.insert(owed_results.size(), r);
  endtask

  // Release every held zero as a plain byte
  task automatic flush_held(input logic pre);
    while (held_zeros != 2'd0) begin
      owe(8'h00, 1'b1, pre, 1'b0, 1'b0, 1'b0);
      held_zeros = held_zeros - 2'd1;
    end
  endtask

  // Work out the results one accepted word causes and advance the state
  task automatic split_word(input logic [7:0] b, input logic last);
    int            first;
    logic          pre;
    split_result_t r;
    first = owed_results.size();
    pre   = !marker_seen;
    if (b == 8'h00) begin
      if (held_zeros < MARKER_ZEROS)
        held_zeros = held_zeros + 2'd1;
      else
        owe(8'h00, 1'b1, pre, 1'b0, 1'b0, 1'b0);
    end else if (b == MARKER_BYTE && held_zeros == MARKER_ZEROS) begin
      owe(8'h00, 1'b0, pre, 1'b1, marker_seen, 1'b0);
      marker_seen = 1'b1;
      held_zeros  = 2'd0;
    end else begin
      flush_held(pre);
      owe(b, 1'b1, pre, 1'b0, 1'b0, 1'b0);
    end
    // Close the tile: flush zeros, end the final unit as kept
    if (last) begin
      flush_held(!marker_seen);
      owe(8'h00, 1'b0, !marker_seen, 1'b1, 1'b1, 1'b1);
      held_zeros  = 2'd0;
      marker_seen = 1'b0;
    end
    // Flag the last result of this word
    if (owed_results.size() > first) begin
      r = owed_results.pop_back();
      r.run_last = 1'b1;
      owed_results.insert(owed_results.size(), r);
    end
  endtask

  always @(posedge clk) begin
    split_result_t want;
    if (!rst_n) begin
      held_zeros  = 2'd0;
      marker_seen = 1'b0;
      owed_results.delete();
    end else begin
      if (in_valid && in_ready)
        split_word(in_data_byte, in_tile_last);
      // Compare each accepted result with the oldest one owed
      if (out_valid && out_ready) begin
        if (owed_results.size() == 0) begin
          report_mismatch($sformatf("result with nothing owed, byte %0h", out_out_byte));
        end else begin
          want = owed_results.pop_front();
          check_field("out_byte", out_out_byte, want.data);
          check_bit("byte_valid", out_byte_valid, want.byte_valid);
          check_bit("in_prefix", out_in_prefix, want.prefix);
          check_bit("unit_end", out_unit_end, want.unit_end);
          check_bit("unit_kept", out_unit_kept, want.kept);
          check_bit("tile_end", out_tile_end, want.tile_end);
          check_bit("run_last", out_run_last, want.run_last);
        end
      end
    end
    owed_count <= owed_results.size();
  end

endmodule

>>> tb/sv/start_code_unit_splitter_tb.sv
// Testbench top for the start code unit splitter: clock, reset, stimulus and verdict.
// Depends on scus_pkg, start_code_unit_splitter and start_code_unit_splitter_chk.
`timescale 1ns / 100ps

module start_code_unit_splitter_tb import scus_pkg::*; ;

  localparam int RANDOM_PER_PHASE = 160;
  localparam int SETTLE_CYCLES    = 12;
  localparam int CYCLE_LIMIT      = 200000;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] in_data_byte = 8'h00;
  logic       in_tile_last = 1'b0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] out_out_byte;
  logic       out_byte_valid;
  logic       out_in_prefix;
  logic       out_unit_end;
  logic       out_unit_kept;
  logic       out_tile_end;
  logic       out_run_last;

  int owed_count;
  int fail_count;
  int send_idle_pct = 7;
  int recv_stall_pct = 62;
  int words_sent = 0;
  int cycles = 0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  start_code_unit_splitter DUT (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_data_byte  (in_data_byte),
    .in_tile_last  (in_tile_last),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_out_byte  (out_out_byte),
    .out_byte_valid(out_byte_valid),
    .out_in_prefix (out_in_prefix),
    .out_unit_end  (out_unit_end),
    .out_unit_kept (out_unit_kept),
    .out_tile_end  (out_tile_end),
    .out_run_last  (out_run_last)
  );

  start_code_unit_splitter_chk checker_i (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_data_byte  (in_data_byte),
    .in_tile_last  (in_tile_last),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_out_byte  (out_out_byte),
    .out_byte_valid(out_byte_valid),
    .out_in_prefix (out_in_prefix),
    .out_unit_end  (out_unit_end),
    .out_unit_kept (out_unit_kept),
    .out_tile_end  (out_tile_end),
    .out_run_last  (out_run_last),
    .owed_count    (owed_count),
    .fail_count    (fail_count)
  );

  // Stall the result channel at random
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Bound the run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Offer one word, idling first at random, and hold it until accepted
  task automatic send_word(input logic [7:0] b, input logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_data_byte <= b;
    in_tile_last <= last;
    do @(posedge clk); while (!in_ready);
    words_sent++;
  endtask

  initial begin
    logic [7:0] tile_q[$];
    int         len;
    int         kind;
    int         nz;
    int         target;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Prefix byte, then a marker closing the discarded prefix
    send_word(8'hFF, 1'b0);
    send_word(8'h00, 1'b0);
    send_word(8'h00, 1'b0);
    send_word(8'h00, 1'b0);
    send_word(MARKER_BYTE, 1'b0);
    send_word(8'hAB, 1'b0);
    // Five zeros before the marker: the extra zeros stay in the unit
    repeat (5) send_word(8'h00, 1'b0);
    send_word(MARKER_BYTE, 1'b0);
    // 01 behind a single zero is plain data
    send_word(8'h00, 1'b0);
    send_word(MARKER_BYTE, 1'b0);
    // Marker on the tile's last word
    send_word(8'h00, 1'b0);
    send_word(8'h00, 1'b0);
    send_word(8'h00, 1'b0);
    send_word(MARKER_BYTE, 1'b1);
    // Tiles with no marker, one ending on held zeros
    send_word(8'h80, 1'b0);
    send_word(8'h7F, 1'b1);
    send_word(8'h00, 1'b0);
    send_word(8'h00, 1'b1);
    // Three held zeros flushed ahead of a data byte on the last word
    send_word(8'h00, 1'b0);
    send_word(8'h00, 1'b0);
    send_word(8'h00, 1'b0);
    send_word(8'h55, 1'b1);

    target = words_sent;
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct  = 7;
          recv_stall_pct = 62;
        end
        1: begin
          send_idle_pct  = 62;
          recv_stall_pct = 7;
        end
        default: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
        end
      endcase
      target += RANDOM_PER_PHASE;
      while (words_sent < target) begin
        if ($urandom_range(99) < 15) begin
          // Noise: arbitrary bytes with tile ends anywhere
          len = $urandom_range(1, 12);
          repeat (len) send_word(8'($urandom_range(255)), $urandom_range(7) == 0);
        end else begin
          // Well-formed tile: markers, zero runs, 01 bytes and data
          tile_q.delete();
          len = $urandom_range(1, 24);
          while (tile_q.size() < len) begin
            kind = $urandom_range(9);
            if (kind < 3) begin
              nz = 3 + $urandom_range(3);
              repeat (nz) tile_q.insert(tile_q.size(), 8'h00);
              tile_q.insert(tile_q.size(), MARKER_BYTE);
            end else if (kind < 5) begin
              nz = $urandom_range(1, 3);
              repeat (nz) tile_q.insert(tile_q.size(), 8'h00);
            end else if (kind == 5) begin
              tile_q.insert(tile_q.size(), MARKER_BYTE);
            end else begin
              tile_q.insert(tile_q.size(), 8'($urandom_range(255)));
            end
          end
          foreach (tile_q[i])
            send_word(tile_q[i], i == tile_q.size() - 1);
        end
      end
    end

    // Drain: drop valid, keep the receiver ready, wait out the pipeline
    in_valid       <= 1'b0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    do @(posedge clk); while (owed_count != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (fail_count == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule

>>> files.f
hdl/scus_pkg.sv
hdl/scus_plan.sv
hdl/start_code_unit_splitter.sv
tb/sv/start_code_unit_splitter_chk.sv
tb/sv/start_code_unit_splitter_tb.sv
